@@ design/dla_pkg.sv @@
// shared constants, types and command bundle for the delay line allpass filter
package dla_pkg;

  localparam int LINE_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int DELAY_W    = ADDR_W + 1;
  localparam int GAIN_W     = 17;
  localparam int SAMPLE_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int PROD_W     = GAIN_W + 1 + SAMPLE_W;
  localparam int FRAC_W     = 16;
  localparam int SCALED_W   = PROD_W - FRAC_W;
  localparam int SUM_W      = SCALED_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_D,
    ST_SUM_S,
    ST_MUL_S,
    ST_EMIT
  } dla_state_t;

  typedef struct packed {
    logic accept;
    logic mult_d;
    logic commit;
    logic mult_s;
    logic load_out;
  } dla_cmd_t;

endpackage

@@ design/dla_ctrl.sv @@
// sequencer for one sample at a time plus the output valid flag
module dla_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dla_pkg::dla_cmd_t cmd
);

  dla_pkg::dla_state_t state, state_next;
  logic can_load;

  assign can_load = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      dla_pkg::ST_IDLE:  if (in_valid) state_next = dla_pkg::ST_MUL_D;
      dla_pkg::ST_MUL_D: state_next = dla_pkg::ST_SUM_S;
      dla_pkg::ST_SUM_S: state_next = dla_pkg::ST_MUL_S;
      dla_pkg::ST_MUL_S: state_next = dla_pkg::ST_EMIT;
      dla_pkg::ST_EMIT:  if (can_load) state_next = dla_pkg::ST_IDLE;
      default:           state_next = dla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      dla_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      dla_pkg::ST_MUL_D: cmd.mult_d   = 1'b1;
      dla_pkg::ST_SUM_S: cmd.commit   = 1'b1;
      dla_pkg::ST_MUL_S: cmd.mult_s   = 1'b1;
      dla_pkg::ST_EMIT:  cmd.load_out = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dla_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/dla_datapath.sv @@
// delay memory, config registers, shared gain multiplier and saturating adders
module dla_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic        [dla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [dla_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic signed [dla_pkg::SAMPLE_W-1:0]    sample_in,
  input  dla_pkg::dla_cmd_t                      cmd,
  output logic signed [dla_pkg::SAMPLE_W-1:0]    sample_out
);

  localparam logic signed [dla_pkg::SUM_W-1:0] SAT_MAX =
    dla_pkg::SUM_W'((1 <<< (dla_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [dla_pkg::SUM_W-1:0] SAT_MIN =
    -dla_pkg::SUM_W'(1 <<< (dla_pkg::SAMPLE_W - 1));

  function automatic logic signed [dla_pkg::SAMPLE_W-1:0] sat(
    input logic signed [dla_pkg::SUM_W-1:0] v
  );
    logic signed [dla_pkg::SAMPLE_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[dla_pkg::SAMPLE_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[dla_pkg::SAMPLE_W-1:0];
    end else begin
      r = v[dla_pkg::SAMPLE_W-1:0];
    end
    return r;
  endfunction

  logic        [dla_pkg::DELAY_W-1:0]  delay_length;
  logic        [dla_pkg::GAIN_W-1:0]   feedback_gain;
  logic        [dla_pkg::ADDR_W-1:0]   write_pointer;
  logic        [dla_pkg::DELAY_W-1:0]  fill_count;
  logic signed [dla_pkg::SAMPLE_W-1:0] delay_mem [dla_pkg::LINE_DEPTH];
  logic signed [dla_pkg::SAMPLE_W-1:0] rd_data;
  logic                                rd_known;
  logic signed [dla_pkg::SAMPLE_W-1:0] x_hold;
  logic signed [dla_pkg::SAMPLE_W-1:0] s_hold;
  logic signed [dla_pkg::PROD_W-1:0]   prod;

  logic        [dla_pkg::ADDR_W-1:0]   rd_addr;
  logic signed [dla_pkg::SAMPLE_W-1:0] d_eff;
  logic signed [dla_pkg::SAMPLE_W-1:0] mul_opnd;
  logic signed [dla_pkg::GAIN_W:0]     gain_s;
  logic signed [dla_pkg::PROD_W-1:0]   biased;
  logic signed [dla_pkg::SCALED_W-1:0] scaled;
  logic signed [dla_pkg::SUM_W-1:0]    s_wide;
  logic signed [dla_pkg::SUM_W-1:0]    y_wide;
  logic signed [dla_pkg::SAMPLE_W-1:0] s_next;

  // entry written delay_length samples ago; a full delay wraps onto the pointer
  assign rd_addr  = dla_pkg::ADDR_W'(write_pointer - delay_length[dla_pkg::ADDR_W-1:0]);
  // entries not yet written since reset read as zero
  assign d_eff    = rd_known ? rd_data : '0;
  assign mul_opnd = cmd.mult_s ? s_hold : d_eff;
  assign gain_s   = $signed({1'b0, feedback_gain});

  // round half up, then floor shift
  assign biased = prod + dla_pkg::PROD_W'(1 <<< (dla_pkg::FRAC_W - 1));
  assign scaled = biased[dla_pkg::PROD_W-1:dla_pkg::FRAC_W];

  assign s_wide = dla_pkg::SUM_W'(x_hold) + dla_pkg::SUM_W'(scaled);
  assign y_wide = dla_pkg::SUM_W'(d_eff) - dla_pkg::SUM_W'(scaled);
  assign s_next = sat(s_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= dla_pkg::DELAY_W'(1);
      feedback_gain <= '0;
      write_pointer <= dla_pkg::ADDR_W'(dla_pkg::LINE_DEPTH - 1);
      fill_count    <= '0;
    end else begin
      if (cfg_write && cfg_index == dla_pkg::REG_DELAY_LENGTH) begin
        if (cfg_data == '0) begin
          delay_length <= dla_pkg::DELAY_W'(1);
        end else if (cfg_data > dla_pkg::CFG_DATA_W'(dla_pkg::LINE_DEPTH)) begin
          delay_length <= dla_pkg::DELAY_W'(dla_pkg::LINE_DEPTH);
        end else begin
          delay_length <= cfg_data[dla_pkg::DELAY_W-1:0];
        end
      end
      if (cfg_write && cfg_index == dla_pkg::REG_FEEDBACK_GAIN) begin
        if (cfg_data > dla_pkg::CFG_DATA_W'(dla_pkg::GAIN_ONE)) begin
          feedback_gain <= dla_pkg::GAIN_ONE;
        end else begin
          feedback_gain <= dla_pkg::GAIN_W'(cfg_data);
        end
      end
      if (cmd.commit) begin
        write_pointer <= write_pointer + 1'b1;
        if (fill_count != dla_pkg::DELAY_W'(dla_pkg::LINE_DEPTH)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data  <= delay_mem[rd_addr];
      rd_known <= (delay_length <= fill_count);
      x_hold   <= sample_in;
    end
    if (cmd.commit) begin
      delay_mem[write_pointer] <= s_next;
      s_hold                   <= s_next;
    end
    if (cmd.mult_d || cmd.mult_s) begin
      prod <= gain_s * mul_opnd;
    end
    if (cmd.load_out) begin
      sample_out <= sat(y_wide);
    end
  end

endmodule

@@ design/delay_line_allpass_filter.sv @@
// top level of the schroeder allpass filter: sequencer plus datapath
// steps: multiply by read value, store s, multiply by s, raise output valid once
//   the output is free; a new sample waits for the last, as the single shared gain
//   multiplier is used twice per sample with a saturating add after each product
// reset: delay 1, gain 0, write pointer at the last entry, delay memory reads as
//   zero until written (tracked by a fill count, no clearing pass)
module delay_line_allpass_filter (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write port
  input  logic                                  cfg_write,
  input  logic        [dla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [dla_pkg::CFG_DATA_W-1:0] cfg_data,
  // input sample request
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [dla_pkg::SAMPLE_W-1:0]   sample_in,
  // output sample request
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dla_pkg::SAMPLE_W-1:0]   sample_out
);

  // step strobes from the sequencer to the datapath
  dla_pkg::dla_cmd_t cmd;

  // sequencer: idle, multiply by read value, form and store s,
  // multiply by s, then load the output register once it is free
  dla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: config registers, delay memory, multiplier, saturation
  dla_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .cmd        (cmd),
    .sample_out (sample_out)
  );

endmodule
